[hw/rtl/cmaa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmaa_pkg
// Shared types and constants for the centered moving average audio unit:
// word layouts, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package cmaa_pkg;

  // Sample width is fixed by the word layout
  localparam int SAMPLE_BITS      = 16;

  // Defaults for the top-level parameters
  localparam int MAX_RADIUS_DEF   = 31;
  localparam int MAX_CHANNELS_DEF = 2;

  // Register port layout
  localparam int RADIUS_W   = 5;
  localparam int CHANNELS_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 1'b0,
    CFG_CHANNELS = 1'b1
  } cfg_idx_e;

  // Input word: one interleaved sample
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip_end;
  } in_word_t;

  // Output word: one filtered sample
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          channel;
    logic                          last;
  } out_word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a sample
    S_UPD,    // update running sum, write ring
    S_DIV,    // shared divider running
    S_OUT,    // result held on the output
    S_STEP,   // advance channel / frame bookkeeping
    S_FRD,    // flush: read old ring entry
    S_FUPD,   // flush: update running sum
    S_FNEXT   // flush: next channel / frame
  } state_e;

endpackage

[hw/rtl/cmaa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmaa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cmaa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 126
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/centered_moving_average_audio_unit.sv]
`timescale 1ns / 1ps
// Sequence: an accepted word runs S_UPD, then S_DIV and S_OUT if a result is due, then
//   S_STEP; the divider takes a SUM_W-bit dividend (SUM_W = 22 by default), one quotient
//   bit per divider cycle. Throughput: one word at a time; a stalled output holds it up.
//   At clip end each flushed frame-channel runs S_FRD, S_FUPD, S_DIV/S_OUT if due, S_FNEXT.
// Reset: rst_ni clears control state, radius = 1, channel count = 1; the sample
//   ring is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// centered_moving_average_audio_unit
// Centered moving average over interleaved audio with edge replication.
// Window sums are kept per channel; every average goes through one shared
// iterative divider by the window length, rounded half away from zero.
// ----------------------------------------------------------------------------
module centered_moving_average_audio_unit #(
  parameter int MAX_RADIUS   = cmaa_pkg::MAX_RADIUS_DEF,
  parameter int MAX_CHANNELS = cmaa_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cmaa_pkg::in_word_t                  in_word_i,
  // output words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cmaa_pkg::out_word_t                 out_word_o,
  // register writes
  input  logic                                cfg_we_i,
  input  logic [cmaa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cmaa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SB        = cmaa_pkg::SAMPLE_BITS;
  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
  localparam int LEN_W     = RAD_W + 1;
  localparam int SLOT_W    = $clog2(WIN_DEPTH);
  localparam int MEM_DEPTH = WIN_DEPTH * MAX_CHANNELS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SUM_W     = SB + LEN_W;
  localparam int CNT_W     = $clog2(SUM_W + 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  cmaa_pkg::state_e state_q, state_d;

  logic [cmaa_pkg::RADIUS_W-1:0]   radius_q;
  logic [cmaa_pkg::CHANNELS_W-1:0] chans_q;

  logic [LEN_W-1:0]         frames_q;
  logic [SLOT_W-1:0]        ws_q;
  logic                     cp_q;
  logic signed [SUM_W-1:0]  sum_q   [MAX_CHANNELS];
  logic signed [SB-1:0]     first_q [MAX_CHANNELS];
  logic signed [SB-1:0]     cur_q   [MAX_CHANNELS];
  logic                     flush_q;
  logic [RAD_W-1:0]         t_q;
  logic                     fch_q;

  // accepted word
  logic signed [SB-1:0]     x_q;
  logic                     end_q;
  logic                     c_q;

  // divider
  logic [SUM_W-1:0]         div_num_q;
  logic [LEN_W-1:0]         div_rem_q;
  logic [CNT_W-1:0]         div_cnt_q;
  logic                     div_neg_q;
  logic                     div_last_q;
  logic                     div_ch_q;

  cmaa_pkg::out_word_t      out_q;

  // --------------------------------------------------------------------------
  // Effective configuration
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0] r_eff;
  logic [LEN_W-1:0] len;
  logic             lch;      // index of the frame's last channel
  logic             c_eff;

  assign r_eff = (radius_q > cmaa_pkg::RADIUS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                               : radius_q[RAD_W-1:0];
  assign len   = {r_eff, 1'b1};
  assign lch   = (MAX_CHANNELS > 1) && (chans_q >= cmaa_pkg::CHANNELS_W'(2));
  assign c_eff = cp_q & lch;

  // --------------------------------------------------------------------------
  // Ring addressing
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]  dist_f;
  logic [LEN_W-1:0]  rd_dist;
  logic [LEN_W:0]    ws_ext;
  logic [LEN_W:0]    rd_slot_w;
  logic [SLOT_W-1:0] rd_slot;
  logic              rd_ch;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SB-1:0]     ram_rdata;
  logic              ram_we;

  assign dist_f  = len - LEN_W'(t_q);
  assign rd_dist = (state_q == cmaa_pkg::S_FRD) ? dist_f : len;
  assign rd_ch   = (state_q == cmaa_pkg::S_FRD) ? fch_q : c_eff;
  assign ws_ext  = (LEN_W + 1)'(ws_q);

  // slot that lies rd_dist frames back, modulo the ring depth
  always_comb begin
    if (ws_ext >= (LEN_W + 1)'(rd_dist)) begin
      rd_slot_w = ws_ext - (LEN_W + 1)'(rd_dist);
    end else begin
      rd_slot_w = ws_ext + (LEN_W + 1)'(WIN_DEPTH) - (LEN_W + 1)'(rd_dist);
    end
  end
  assign rd_slot = rd_slot_w[SLOT_W-1:0];

  assign ram_raddr = ADDR_W'(rd_slot) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(rd_ch);
  assign ram_waddr = ADDR_W'(ws_q) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(c_q);

  cmaa_ram #(
    .WIDTH (SB),
    .DEPTH (MEM_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (x_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Running sum update (normal step and flush share it)
  // --------------------------------------------------------------------------
  logic                    sel_ch;
  logic signed [SB-1:0]    add_in;
  logic signed [SB-1:0]    old_s;
  logic signed [SUM_W-1:0] sum_init;
  logic signed [SUM_W-1:0] sum_new;
  logic                    emit_now;
  logic                    last_now;
  logic [SUM_W-1:0]        mag;

  assign sel_ch = flush_q ? fch_q : c_q;
  assign add_in = flush_q ? cur_q[fch_q] : x_q;

  always_comb begin
    if (flush_q) begin
      old_s = (dist_f > frames_q) ? first_q[fch_q] : $signed(ram_rdata);
    end else begin
      old_s = (frames_q < len) ? first_q[c_q] : $signed(ram_rdata);
    end
  end

  assign sum_init = SUM_W'($signed({1'b0, len})) * SUM_W'(x_q);

  always_comb begin
    if (!flush_q && (frames_q == '0)) begin
      sum_new = sum_init;
    end else begin
      sum_new = sum_q[sel_ch] + SUM_W'(add_in) - SUM_W'(old_s);
    end
  end

  // result due now, and whether it closes the clip
  always_comb begin
    if (flush_q) begin
      emit_now = ((LEN_W + 1)'(frames_q) + (LEN_W + 1)'(t_q)) >= (LEN_W + 1)'(r_eff);
      last_now = (t_q == r_eff) && (fch_q == lch);
    end else begin
      emit_now = frames_q >= LEN_W'(r_eff);
      last_now = end_q && (c_q == lch) && (r_eff == '0);
    end
  end

  // dividend: |sum| + len/2
  assign mag = (sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new)) + SUM_W'(r_eff);

  // --------------------------------------------------------------------------
  // Divider step: one restoring quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [LEN_W:0]   rem_sh;
  logic             rem_ge;
  logic [LEN_W-1:0] rem_nx;
  logic [SUM_W-1:0] num_nx;
  logic [SB-1:0]    q_mag;
  logic [SB-1:0]    q_signed;

  assign rem_sh   = {div_rem_q, div_num_q[SUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, len};
  assign rem_nx   = rem_ge ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
  assign num_nx   = {div_num_q[SUM_W-2:0], rem_ge};
  assign q_mag    = num_nx[SB-1:0];
  assign q_signed = div_neg_q ? SB'('0 - q_mag) : q_mag;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cmaa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = cmaa_pkg::S_UPD;
      end
      cmaa_pkg::S_UPD: begin
        state_d = emit_now ? cmaa_pkg::S_DIV : cmaa_pkg::S_STEP;
      end
      cmaa_pkg::S_DIV: begin
        if (div_cnt_q == CNT_W'(1)) state_d = cmaa_pkg::S_OUT;
      end
      cmaa_pkg::S_OUT: begin
        if (!out_stall_i) state_d = flush_q ? cmaa_pkg::S_FNEXT : cmaa_pkg::S_STEP;
      end
      cmaa_pkg::S_STEP: begin
        if ((c_q == lch) && end_q && (r_eff != '0)) begin
          state_d = cmaa_pkg::S_FRD;
        end else begin
          state_d = cmaa_pkg::S_IDLE;
        end
      end
      cmaa_pkg::S_FRD: begin
        state_d = cmaa_pkg::S_FUPD;
      end
      cmaa_pkg::S_FUPD: begin
        state_d = emit_now ? cmaa_pkg::S_DIV : cmaa_pkg::S_FNEXT;
      end
      cmaa_pkg::S_FNEXT: begin
        if ((fch_q == lch) && (t_q == r_eff)) begin
          state_d = cmaa_pkg::S_IDLE;
        end else begin
          state_d = cmaa_pkg::S_FRD;
        end
      end
      default: state_d = cmaa_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer
  // --------------------------------------------------------------------------
  logic upd_en;
  logic div_load;
  logic clear_clip;
  logic cfg_hit;

  always_comb begin
    in_stall_o  = (state_q != cmaa_pkg::S_IDLE);
    out_valid_o = (state_q == cmaa_pkg::S_OUT);
    ram_we      = (state_q == cmaa_pkg::S_UPD);
    upd_en      = (state_q == cmaa_pkg::S_UPD) || (state_q == cmaa_pkg::S_FUPD);
    div_load    = upd_en && emit_now;
    cfg_hit     = cfg_we_i;
    clear_clip  = cfg_hit
               || ((state_q == cmaa_pkg::S_STEP) && (c_q == lch) && end_q
                   && (r_eff == '0))
               || ((state_q == cmaa_pkg::S_FNEXT) && (fch_q == lch) && (t_q == r_eff));
  end

  assign out_word_o = out_q;

  // --------------------------------------------------------------------------
  // Control and clip state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cmaa_pkg::S_IDLE;
      radius_q  <= cmaa_pkg::RADIUS_W'(1);
      chans_q   <= cmaa_pkg::CHANNELS_W'(1);
      frames_q  <= '0;
      ws_q      <= '0;
      cp_q      <= 1'b0;
      flush_q   <= 1'b0;
      t_q       <= '0;
      fch_q     <= 1'b0;
      div_cnt_q <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sum_q[i]   <= '0;
        first_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_hit) begin
        unique case (cfg_idx_i)
          cmaa_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[cmaa_pkg::RADIUS_W-1:0];
          cmaa_pkg::CFG_CHANNELS: chans_q  <= cfg_data_i[cmaa_pkg::CHANNELS_W-1:0];
          default: ;
        endcase
      end

      // running sum and first frame
      if (upd_en) begin
        sum_q[sel_ch] <= sum_new;
        if (!flush_q && (frames_q == '0)) first_q[c_q] <= x_q;
      end

      // divider counter
      if (div_load) begin
        div_cnt_q <= CNT_W'(SUM_W);
      end else if (state_q == cmaa_pkg::S_DIV) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end

      // channel / frame bookkeeping
      if (state_q == cmaa_pkg::S_STEP) begin
        if (c_q != lch) begin
          cp_q <= 1'b1;
        end else begin
          cp_q <= 1'b0;
          if (!end_q) begin
            ws_q <= (ws_q == SLOT_W'(WIN_DEPTH - 1)) ? '0 : ws_q + 1'b1;
            if (frames_q != LEN_W'(WIN_DEPTH)) frames_q <= frames_q + 1'b1;
          end else if (r_eff != '0) begin
            flush_q <= 1'b1;
            t_q     <= RAD_W'(1);
            fch_q   <= 1'b0;
          end
        end
      end

      // flush walk: channels inside, frames outside
      if (state_q == cmaa_pkg::S_FNEXT) begin
        if (fch_q == lch) begin
          fch_q <= 1'b0;
          t_q   <= t_q + 1'b1;
        end else begin
          fch_q <= 1'b1;
        end
      end

      // end of clip or register write
      if (clear_clip) begin
        frames_q <= '0;
        ws_q     <= '0;
        cp_q     <= 1'b0;
        flush_q  <= 1'b0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          sum_q[i]   <= '0;
          first_q[i] <= '0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // capture the accepted word
    if ((state_q == cmaa_pkg::S_IDLE) && in_valid_i) begin
      x_q   <= in_word_i.sample;
      end_q <= in_word_i.clip_end;
      c_q   <= c_eff;
    end

    // newest frame per channel
    if (state_q == cmaa_pkg::S_UPD) cur_q[c_q] <= x_q;

    // divider
    if (div_load) begin
      div_num_q  <= mag;
      div_rem_q  <= '0;
      div_neg_q  <= sum_new[SUM_W-1];
      div_last_q <= last_now;
      div_ch_q   <= sel_ch;
    end else if (state_q == cmaa_pkg::S_DIV) begin
      div_num_q <= num_nx;
      div_rem_q <= rem_nx;
    end

    // output register
    if ((state_q == cmaa_pkg::S_DIV) && (div_cnt_q == CNT_W'(1))) begin
      out_q.filtered <= $signed(q_signed);
      out_q.channel  <= div_ch_q;
      out_q.last     <= div_last_q;
    end
  end

endmodule

[hw/rtl/cmaa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmaa_checker
// Port-level checks for the centered moving average audio unit, bound to
// the top level.
// ----------------------------------------------------------------------------
module cmaa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cmaa_pkg::out_word_t out_word_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // an accepted word keeps the input stalled in the next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a word");

  // no new word while a result waits
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // the divider needs cycles between two results
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("results back to back");

endmodule

bind centered_moving_average_audio_unit cmaa_checker u_cmaa_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the centered moving average audio unit. A short
// directed run covers the sample extremes, stray clip ends, clips shorter than
// the radius, a zero radius and a clip that a register write abandons. Random
// clips then run under several radius and channel settings, the extremes among
// them. Every filtered word is predicted when its sample is taken and checked
// in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF    = 5;
  localparam int RING_DEPTH  = 2 * cmaa_pkg::MAX_RADIUS_DEF + 1;
  localparam int NCH         = cmaa_pkg::MAX_CHANNELS_DEF;
  localparam int SB          = cmaa_pkg::SAMPLE_BITS;
  localparam int SUM_W       = 22;
  localparam int SETTLE_CYC  = 3 + SUM_W + 15;
  localparam int CYCLE_LIMIT = 400000;

  // DUT ports; the inputs are known from time zero
  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  cmaa_pkg::in_word_t              in_word_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  cmaa_pkg::out_word_t             out_word_o;
  logic                            cfg_we_i    = 1'b0;
  logic [cmaa_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [cmaa_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // stimulus and checking bookkeeping
  cmaa_pkg::in_word_t  pending_words[$];
  cmaa_pkg::out_word_t expected_words[$];
  cmaa_pkg::out_word_t want_word;
  int unsigned send_idle_pct  = 17;
  int unsigned recv_stall_pct = 74;
  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;

  // predictor state: registers, window ring, per-channel sums
  logic [cmaa_pkg::RADIUS_W-1:0]   radius_q;
  logic [cmaa_pkg::CHANNELS_W-1:0] chans_q;
  int                              ring [RING_DEPTH][NCH];
  int                              win_sum [NCH];
  int                              first_smp [NCH];
  int                              frames_seen;
  int                              chan_pos;
  int                              wr_slot;

  centered_moving_average_audio_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int eff_chans();
    if (chans_q == 0) return 1;
    return (chans_q > NCH) ? NCH : int'(chans_q);
  endfunction

  function automatic void clear_clip();
    foreach (ring[i, j]) ring[i][j] = 0;
    foreach (win_sum[i]) begin
      win_sum[i]   = 0;
      first_smp[i] = 0;
    end
    frames_seen = 0;
    chan_pos    = 0;
    wr_slot     = 0;
  endfunction

  // ring entry span frames back from the current slot
  function automatic int ring_back(int ch, int span);
    int slot;
    slot = (wr_slot + RING_DEPTH - (span % RING_DEPTH)) % RING_DEPTH;
    return ring[slot][ch];
  endfunction

  // window average, rounded half away from zero
  function automatic cmaa_pkg::out_word_t filtered_word(int sum, int len, int ch);
    cmaa_pkg::out_word_t o;
    int                  mag;
    int                  q;
    mag        = (sum < 0) ? -sum : sum;
    q          = (mag + len / 2) / len;
    q          = (sum < 0) ? -q : q;
    o.filtered = q[SB-1:0];
    o.channel  = ch[0];
    o.last     = 1'b0;
    return o;
  endfunction

  task automatic predict_word(cmaa_pkg::in_word_t w);
    cmaa_pkg::out_word_t burst[$];
    int                  r;
    int                  chans;
    int                  len;
    int                  m;
    int                  c;
    int                  x;
    int                  old;
    int                  span;
    r     = (radius_q > cmaa_pkg::MAX_RADIUS_DEF) ? cmaa_pkg::MAX_RADIUS_DEF
                                                  : int'(radius_q);
    chans = eff_chans();
    len   = 2 * r + 1;
    m     = frames_seen;
    c     = chan_pos;
    x     = $signed(w.sample);
    if (c >= chans) c = 0;

    // slide the window of this channel
    if (m == 0) begin
      first_smp[c] = x;
      win_sum[c]   = len * x;
    end else begin
      old        = (m < len) ? first_smp[c] : ring_back(c, len);
      win_sum[c] += x - old;
    end
    ring[wr_slot][c] = x;
    if (m >= r) burst.push_back(filtered_word(win_sum[c], len, c));

    if (c + 1 < chans) begin
      chan_pos = c + 1;
    end else begin
      chan_pos = 0;
      if (!w.clip_end) begin
        wr_slot = (wr_slot + 1) % RING_DEPTH;
        if (frames_seen < RING_DEPTH) frames_seen++;
      end else begin
        // flush: the last frame stands in for frames past the end
        for (int t = 1; t <= r; t++) begin
          span = len - t;
          for (int ch = 0; ch < chans; ch++) begin
            old          = (span > m) ? first_smp[ch] : ring_back(ch, span);
            win_sum[ch] += ring_back(ch, 0) - old;
            if (r - t <= m) burst.push_back(filtered_word(win_sum[ch], len, ch));
          end
        end
        if (burst.size() > 0) burst[$].last = 1'b1;
        clear_clip();
      end
    end
    foreach (burst[i]) expected_words.push_back(burst[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(int s, bit e);
    cmaa_pkg::in_word_t w;
    w.sample   = s[SB-1:0];
    w.clip_end = e;
    pending_words.push_back(w);
  endtask

  // mostly full-range noise, with extremes and small values mixed in
  function automatic int rand_sample();
    logic [SB-1:0] raw;
    int unsigned   pick;
    pick = $urandom_range(15);
    raw  = $urandom();
    if (pick == 0) return -32768;
    if (pick == 1) return 32767;
    if (pick < 6) return int'($urandom_range(200)) - 100;
    return $signed(raw);
  endfunction

  // well-formed clips with random content; a stray clip_end now and then on
  // a leading channel, and the last clip cut short when the word budget ends
  task automatic queue_clips(int unsigned n_words, int unsigned min_frames,
                             int unsigned max_frames);
    int unsigned chans;
    int unsigned frames;
    int unsigned sent;
    bit          e;
    chans = eff_chans();
    sent  = 0;
    while (sent < n_words) begin
      frames = $urandom_range(max_frames, min_frames);
      for (int unsigned f = 0; f < frames && sent < n_words; f++) begin
        for (int unsigned ch = 0; ch < chans && sent < n_words; ch++) begin
          e = (f == frames - 1) && (ch == chans - 1);
          if (ch + 1 < chans && $urandom_range(11) == 0) e = 1'b1;
          queue_word(rand_sample(), e);
          sent++;
        end
      end
    end
  endtask

  task automatic write_reg(cmaa_pkg::cfg_idx_e idx,
                           logic [cmaa_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == cmaa_pkg::CFG_RADIUS) radius_q = data[cmaa_pkg::RADIUS_W-1:0];
    else chans_q = data[cmaa_pkg::CHANNELS_W-1:0];
    // any write drops the clip in progress
    clear_clip();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all words taken, all results seen, then let the last word finish
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic setup(logic [cmaa_pkg::CFG_DATA_W-1:0] radius,
                       logic [cmaa_pkg::CFG_DATA_W-1:0] chans,
                       int unsigned send_pct, int unsigned stall_pct);
    wait_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    write_reg(cmaa_pkg::CFG_RADIUS, radius);
    write_reg(cmaa_pkg::CFG_CHANNELS, chans);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // predict on every accepted input word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) predict_word(in_word_i);
  end

  // ---------------------------------------------------------------------------
  // Output monitor and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: filtered %0d channel %0d last %0d",
                 out_word_o.filtered, out_word_o.channel, out_word_o.last);
          errors++;
        end else begin
          want_word = expected_words.pop_front();
          if (out_word_o.filtered !== want_word.filtered) begin
            $error("filtered: expected %0d, got %0d",
                   want_word.filtered, out_word_o.filtered);
            errors++;
          end
          if (out_word_o.channel !== want_word.channel) begin
            $error("channel: expected %0d, got %0d",
                   want_word.channel, out_word_o.channel);
            errors++;
          end
          if (out_word_o.last !== want_word.last) begin
            $error("last: expected %0d, got %0d", want_word.last, out_word_o.last);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    radius_q = 5'd1;
    chans_q  = 2'd1;
    clear_clip();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings (radius 1, mono): extremes, then a one-frame clip
    queue_word(32767, 1'b0);
    queue_word(-32768, 1'b0);
    queue_word(0, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(32767, 1'b1);
    queue_word(-32768, 1'b1);

    // radius 4, stereo, junk in the upper data bits: clips shorter than the
    // radius, and a clip_end on channel 0 that must be ignored
    setup(5'd4, 5'b11110, 17, 74);
    queue_word(32767, 1'b0);
    queue_word(-32768, 1'b0);
    queue_word(-1, 1'b1);
    queue_word(1, 1'b1);
    queue_word(-32768, 1'b0);
    queue_word(32767, 1'b1);

    // zero radius: each sample passes straight through; the trailing word
    // opens a clip that the next register write abandons
    setup(5'd0, 5'b00010, 17, 74);
    queue_word(100, 1'b0);
    queue_word(-100, 1'b0);
    queue_word(32767, 1'b0);
    queue_word(-32768, 1'b1);
    queue_word(5, 1'b0);

    // random clips, receiver mostly stalled
    setup(5'd2, 5'b00010, 17, 74);
    queue_clips(12, 1, 8);
    // largest radius, one clip long enough to fill and wrap the ring
    setup(5'd31, {3'($urandom_range(7)), 2'd1}, 17, 74);
    queue_clips(66, 66, 66);

    // sender mostly idle; out-of-range channel counts
    setup(5'd0, {3'($urandom_range(7)), 2'd3}, 74, 17);
    queue_clips(8, 1, 6);
    setup(5'd5, {3'($urandom_range(7)), 2'd0}, 74, 17);
    queue_clips(8, 1, 12);

    // no idling on either side
    setup(5'd31, {3'($urandom_range(7)), 2'd2}, 0, 0);
    queue_clips(10, 1, 10);
    setup(5'($urandom_range(30, 3)), {3'($urandom_range(7)), 2'd2}, 0, 0);
    queue_clips(10, 1, 20);

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cmaa_pkg.sv
hw/rtl/cmaa_ram.sv
hw/rtl/centered_moving_average_audio_unit.sv
hw/rtl/cmaa_checker.sv
verif/tb.sv
